>>> rtl/priority_task_picker_macros.svh
`ifndef PRIORITY_TASK_PICKER_MACROS_SVH
`define PRIORITY_TASK_PICKER_MACROS_SVH

// same-cycle implication
`define PTP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("priority_task_picker: assertion failed");

// next-cycle implication
`define PTP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("priority_task_picker: assertion failed");

`endif

>>> rtl/ptp_pkg.sv
package ptp_pkg;

  localparam int NAME_W     = 64;
  localparam int PRIO_W     = 8;
  localparam int BURST_W    = 16;
  localparam int TIME_W     = 32;
  localparam int COUNT_W    = 16;
  localparam int IN_DATA_W  = NAME_W + PRIO_W + BURST_W;
  localparam int OUT_DATA_W = NAME_W + PRIO_W + BURST_W + TIME_W + COUNT_W;
  localparam int IN_USER_W  = 1;
  localparam int OUT_USER_W = 2;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_PICK = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STS_ADDED  = 2'd0,
    STS_FULL   = 2'd1,
    STS_PICKED = 2'd2,
    STS_EMPTY  = 2'd3
  } status_t;

  typedef struct packed {
    logic               valid;
    logic [NAME_W-1:0]  name;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
  } entry_t;

endpackage

>>> rtl/priority_task_picker.sv
// A pick scans the full table before its result goes valid.
// An add scans only up to the lowest free slot, where it writes the new entry.
// Add on a full table and pick on an empty table skip the scan and report their status.
// One transaction at a time; in_tready rises in the same cycle as the result goes valid,
// and a new result waits in ST_DONE until out_tready takes the previous one.
// Reset: synchronous, then a clearing pass over all TABLE_DEPTH entries with in_tready low.
`include "priority_task_picker_macros.svh"

module priority_task_picker #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // name_key[63:0], task_priority[71:64], burst_length[87:72]
  input  logic [ptp_pkg::IN_DATA_W-1:0]    in_tdata,
  // operation[0]
  input  logic [ptp_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // picked_name[63:0], picked_priority[71:64], picked_burst[87:72],
  // elapsed_time[119:88], dispatch_count[135:120]
  output logic [ptp_pkg::OUT_DATA_W-1:0]   out_tdata,
  // status[1:0]
  output logic [ptp_pkg::OUT_USER_W-1:0]   out_tuser
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

  state_t                        state_r;
  logic [AW-1:0]                 clr_idx_r;
  logic [AW-1:0]                 iss_idx_r;
  logic                          iss_done_r;
  logic                          chk_vld_r;
  logic [AW-1:0]                 chk_idx_r;

  ptp_pkg::op_t                  op_r;
  logic [ptp_pkg::NAME_W-1:0]    key_r;
  logic [ptp_pkg::PRIO_W-1:0]    pri_r;
  logic [ptp_pkg::BURST_W-1:0]   burst_r;

  logic                          best_found_r;
  logic [AW-1:0]                 best_idx_r;
  logic [ptp_pkg::NAME_W-1:0]    best_name_r;
  logic [ptp_pkg::PRIO_W-1:0]    best_pri_r;
  logic [ptp_pkg::BURST_W-1:0]   best_burst_r;

  logic [CW-1:0]                 cnt_r;
  logic [ptp_pkg::TIME_W-1:0]    elapsed_r;
  logic [ptp_pkg::COUNT_W-1:0]   dispatch_r;

  ptp_pkg::status_t              res_status_r;
  logic [ptp_pkg::NAME_W-1:0]    res_name_r;
  logic [ptp_pkg::PRIO_W-1:0]    res_pri_r;
  logic [ptp_pkg::BURST_W-1:0]   res_burst_r;

  logic                          out_tvalid_r;
  logic [ptp_pkg::OUT_DATA_W-1:0] out_tdata_r;
  logic [ptp_pkg::OUT_USER_W-1:0] out_tuser_r;

  logic                          tbl_we;
  logic [AW-1:0]                 tbl_wr_addr;
  ptp_pkg::entry_t               tbl_wr_data;
  ptp_pkg::entry_t               tbl_rd_data;

  logic                          cand_better;
  logic [ptp_pkg::TIME_W:0]      elapsed_sum;
  logic                          in_acc;
  logic                          out_free;

  ptp_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_addr (iss_idx_r),
    .rd_data (tbl_rd_data)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign cand_better = tbl_rd_data.valid &&
                       (!best_found_r ||
                        (tbl_rd_data.prio > best_pri_r) ||
                        ((tbl_rd_data.prio == best_pri_r) &&
                         (tbl_rd_data.name < best_name_r)));

  assign elapsed_sum = {1'b0, elapsed_r} + (ptp_pkg::TIME_W + 1)'(best_burst_r);

  always_comb begin
    tbl_we      = 1'b0;
    tbl_wr_addr = best_idx_r;
    tbl_wr_data = '0;
    if (state_r == ST_CLEAR) begin
      tbl_we      = 1'b1;
      tbl_wr_addr = clr_idx_r;
    end else if (state_r == ST_WRITE) begin
      tbl_we = 1'b1;
      if (op_r == ptp_pkg::OP_ADD) begin
        tbl_wr_data = '{valid: 1'b1, name: key_r, prio: pri_r, burst: burst_r};
      end else begin
        tbl_wr_data = '{valid: 1'b0, name: best_name_r, prio: best_pri_r,
                        burst: best_burst_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_idx_r    <= '0;
      iss_idx_r    <= '0;
      iss_done_r   <= 1'b0;
      chk_vld_r    <= 1'b0;
      best_found_r <= 1'b0;
      cnt_r        <= '0;
      elapsed_r    <= '0;
      dispatch_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if ((state_r == ST_DONE) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == LAST_IDX) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            op_r         <= ptp_pkg::op_t'(in_tuser[0]);
            key_r        <= in_tdata[63:0];
            pri_r        <= in_tdata[71:64];
            burst_r      <= in_tdata[87:72];
            best_found_r <= 1'b0;
            iss_idx_r    <= '0;
            iss_done_r   <= 1'b0;
            chk_vld_r    <= 1'b0;
            res_name_r   <= '0;
            res_pri_r    <= '0;
            res_burst_r  <= '0;
            if ((ptp_pkg::op_t'(in_tuser[0]) == ptp_pkg::OP_ADD) && (cnt_r == FULL_CNT)) begin
              res_status_r <= ptp_pkg::STS_FULL;
              state_r      <= ST_DONE;
            end else if ((ptp_pkg::op_t'(in_tuser[0]) == ptp_pkg::OP_PICK) &&
                         (cnt_r == '0)) begin
              res_status_r <= ptp_pkg::STS_EMPTY;
              state_r      <= ST_DONE;
            end else begin
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (!iss_done_r) begin
            iss_idx_r <= iss_idx_r + 1'b1;
            chk_vld_r <= 1'b1;
            chk_idx_r <= iss_idx_r;
            if (iss_idx_r == LAST_IDX) begin
              iss_done_r <= 1'b1;
            end
          end else begin
            chk_vld_r <= 1'b0;
          end
          if (chk_vld_r) begin
            if (op_r == ptp_pkg::OP_ADD) begin
              if (!tbl_rd_data.valid) begin
                best_idx_r <= chk_idx_r;
                state_r    <= ST_WRITE;
              end
            end else begin
              if (cand_better) begin
                best_found_r <= 1'b1;
                best_idx_r   <= chk_idx_r;
                best_name_r  <= tbl_rd_data.name;
                best_pri_r   <= tbl_rd_data.prio;
                best_burst_r <= tbl_rd_data.burst;
              end
              if (chk_idx_r == LAST_IDX) begin
                state_r <= ST_WRITE;
              end
            end
          end
        end
        ST_WRITE: begin
          if (op_r == ptp_pkg::OP_ADD) begin
            cnt_r        <= cnt_r + 1'b1;
            res_status_r <= ptp_pkg::STS_ADDED;
          end else begin
            cnt_r        <= cnt_r - 1'b1;
            elapsed_r    <= elapsed_sum[ptp_pkg::TIME_W] ? '1
                                                         : elapsed_sum[ptp_pkg::TIME_W-1:0];
            if (dispatch_r != '1) begin
              dispatch_r <= dispatch_r + 1'b1;
            end
            res_status_r <= ptp_pkg::STS_PICKED;
            res_name_r   <= best_name_r;
            res_pri_r    <= best_pri_r;
            res_burst_r  <= best_burst_r;
          end
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_tdata_r  <= {dispatch_r, elapsed_r, res_burst_r, res_pri_r, res_name_r};
            out_tuser_r  <= res_status_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_CLEAR;
        end
      endcase
    end
  end

  `PTP_ASSERT_IMP(a_we_only_clear_or_write, clk, rst_n, tbl_we,
                  (state_r == ST_CLEAR) || (state_r == ST_WRITE))
  `PTP_ASSERT_NXT(a_full_add_reports_full, clk, rst_n,
                  in_acc && (ptp_pkg::op_t'(in_tuser[0]) == ptp_pkg::OP_ADD) &&
                  (cnt_r == FULL_CNT),
                  (state_r == ST_DONE) && (res_status_r == ptp_pkg::STS_FULL))
  `PTP_ASSERT_IMP(a_pick_has_entry, clk, rst_n,
                  (state_r == ST_WRITE) && (op_r == ptp_pkg::OP_PICK),
                  best_found_r && (cnt_r != '0))
  `PTP_ASSERT_IMP(a_count_bounded, clk, rst_n, state_r != ST_CLEAR, cnt_r <= FULL_CNT)

endmodule

>>> rtl/ptp_table.sv
module ptp_table #(
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  ptp_pkg::entry_t  wr_data,
  input  logic [AW-1:0]    rd_addr,
  output ptp_pkg::entry_t  rd_data
);

  ptp_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> dv/priority_task_picker_check.sv
`timescale 1ns / 100ps

module priority_task_picker_check #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // name_key[63:0], task_priority[71:64], burst_length[87:72]
  input  logic [ptp_pkg::IN_DATA_W-1:0]   in_tdata,
  // operation[0]
  input  logic [ptp_pkg::IN_USER_W-1:0]   in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // picked_name[63:0], picked_priority[71:64], picked_burst[87:72],
  // elapsed_time[119:88], dispatch_count[135:120]
  input  logic [ptp_pkg::OUT_DATA_W-1:0]  out_tdata,
  // status[1:0]
  input  logic [ptp_pkg::OUT_USER_W-1:0]  out_tuser,
  output int                              fail_count,
  output int                              pending_count
);

  typedef struct packed {
    ptp_pkg::status_t             status;
    logic [ptp_pkg::NAME_W-1:0]   name;
    logic [ptp_pkg::PRIO_W-1:0]   prio;
    logic [ptp_pkg::BURST_W-1:0]  burst;
    logic [ptp_pkg::TIME_W-1:0]   elapsed;
    logic [ptp_pkg::COUNT_W-1:0]  dispatched;
  } outcome_t;

  logic                          slot_used  [TABLE_DEPTH];
  logic [ptp_pkg::NAME_W-1:0]    slot_name  [TABLE_DEPTH];
  logic [ptp_pkg::PRIO_W-1:0]    slot_prio  [TABLE_DEPTH];
  logic [ptp_pkg::BURST_W-1:0]   slot_burst [TABLE_DEPTH];
  logic [ptp_pkg::TIME_W-1:0]    elapsed_total;
  logic [ptp_pkg::COUNT_W-1:0]   dispatch_total;

  outcome_t awaited_outcomes[$];
  outcome_t want;
  outcome_t got;
  int       errors = 0;
  int       outstanding = 0;

  assign fail_count    = errors;
  assign pending_count = outstanding;

  function automatic outcome_t scheduler_outcome(input ptp_pkg::op_t op,
                                                 input logic [ptp_pkg::NAME_W-1:0] key,
                                                 input logic [ptp_pkg::PRIO_W-1:0] pri,
                                                 input logic [ptp_pkg::BURST_W-1:0] bur);
    outcome_t r;
    int       i;
    int       best;
    r    = '0;
    best = -1;
    if (op == ptp_pkg::OP_ADD) begin
      r.status = ptp_pkg::STS_FULL;
      for (i = 0; i < TABLE_DEPTH; i++) begin
        if (!slot_used[i]) begin
          slot_used[i]  = 1'b1;
          slot_name[i]  = key;
          slot_prio[i]  = pri;
          slot_burst[i] = bur;
          r.status      = ptp_pkg::STS_ADDED;
          break;
        end
      end
    end else begin
      // highest priority, then smallest name, then lowest slot
      for (i = 0; i < TABLE_DEPTH; i++) begin
        if (slot_used[i] && (best < 0 || slot_prio[i] > slot_prio[best] ||
            (slot_prio[i] == slot_prio[best] && slot_name[i] < slot_name[best])))
          best = i;
      end
      if (best < 0) begin
        r.status = ptp_pkg::STS_EMPTY;
      end else begin
        slot_used[best] = 1'b0;
        if ({ptp_pkg::TIME_W{1'b1}} - elapsed_total < ptp_pkg::TIME_W'(slot_burst[best]))
          elapsed_total = {ptp_pkg::TIME_W{1'b1}};
        else
          elapsed_total = elapsed_total + ptp_pkg::TIME_W'(slot_burst[best]);
        if (dispatch_total != {ptp_pkg::COUNT_W{1'b1}})
          dispatch_total = dispatch_total + 1'b1;
        r.status = ptp_pkg::STS_PICKED;
        r.name   = slot_name[best];
        r.prio   = slot_prio[best];
        r.burst  = slot_burst[best];
      end
    end
    r.elapsed    = elapsed_total;
    r.dispatched = dispatch_total;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [63:0] exp_val,
                             input logic [63:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_val, act_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) slot_used[i] = 1'b0;
      elapsed_total  = '0;
      dispatch_total = '0;
      awaited_outcomes.delete();
      outstanding = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        awaited_outcomes.push_back(scheduler_outcome(ptp_pkg::op_t'(in_tuser[0]),
                                                     in_tdata[63:0],
                                                     in_tdata[71:64],
                                                     in_tdata[87:72]));
      end
      if (out_tvalid && out_tready) begin
        got.status     = ptp_pkg::status_t'(out_tuser[1:0]);
        got.name       = out_tdata[63:0];
        got.prio       = out_tdata[71:64];
        got.burst      = out_tdata[87:72];
        got.elapsed    = out_tdata[119:88];
        got.dispatched = out_tdata[135:120];
        if (awaited_outcomes.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, actual %0h %0h",
                   $time, out_tuser, out_tdata);
          errors++;
        end else begin
          want = awaited_outcomes.pop_front();
          check_field("status", 64'(want.status), 64'(got.status));
          check_field("picked_name", want.name, got.name);
          check_field("picked_priority", 64'(want.prio), 64'(got.prio));
          check_field("picked_burst", 64'(want.burst), 64'(got.burst));
          check_field("elapsed_time", 64'(want.elapsed), 64'(got.elapsed));
          check_field("dispatch_count", 64'(want.dispatched), 64'(got.dispatched));
        end
      end
      outstanding = awaited_outcomes.size();
    end
  end

endmodule

>>> dv/priority_task_picker_test.sv
`timescale 1ns / 100ps

module priority_task_picker_test;

  localparam int TABLE_DEPTH = 32;

  logic                                 clk = 1'b0;
  logic                                 rst_n;
  logic                                 in_tvalid;
  logic                                 in_tready;
  logic [ptp_pkg::IN_DATA_W-1:0]        in_tdata;
  logic [ptp_pkg::IN_USER_W-1:0]        in_tuser;
  logic                                 out_tvalid;
  logic                                 out_tready = 1'b0;
  logic [ptp_pkg::OUT_DATA_W-1:0]       out_tdata;
  logic [ptp_pkg::OUT_USER_W-1:0]       out_tuser;
  int                                   fail_count;
  int                                   pending_count;
  int                                   send_gap_pct = 0;
  int                                   recv_stall_pct = 0;

  always #2 clk = ~clk;

  priority_task_picker #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  priority_task_picker_check #(.TABLE_DEPTH(TABLE_DEPTH)) u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_task(input ptp_pkg::op_t op,
                           input logic [ptp_pkg::NAME_W-1:0] key,
                           input logic [ptp_pkg::PRIO_W-1:0] pri,
                           input logic [ptp_pkg::BURST_W-1:0] bur);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {bur, pri, key};
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // small pool of short names so ties on name are common
  function automatic logic [ptp_pkg::NAME_W-1:0] random_name();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return {"JOB", 8'h30 + 8'($urandom_range(3)), 32'd0};
      5:             return '0;
      6:             return '1;
      default:       return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [ptp_pkg::PRIO_W-1:0] random_prio();
    case ($urandom_range(9))
      0:             return '0;
      1:             return '1;
      2, 3, 4, 5:    return 8'($urandom_range(100, 103));
      default:       return 8'($urandom);
    endcase
  endfunction

  function automatic logic [ptp_pkg::BURST_W-1:0] random_burst();
    case ($urandom_range(9))
      0:             return '0;
      1:             return '1;
      default:       return 16'($urandom);
    endcase
  endfunction

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int phase;
    int n;
    int run_left;
    int add_pct;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    run_left  = 0;
    add_pct   = 50;
    send_gap_pct   = 7;
    recv_stall_pct = 47;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_task(ptp_pkg::OP_PICK, '0, '0, '0);
    send_task(ptp_pkg::OP_ADD, '0, '0, '0);
    send_task(ptp_pkg::OP_ADD, '1, '1, '1);
    send_task(ptp_pkg::OP_ADD, {"ALPHA", 24'd0}, 8'd255, 16'd1);
    send_task(ptp_pkg::OP_ADD, {"ALPHA", 24'd0}, 8'd255, 16'd2);
    send_task(ptp_pkg::OP_ADD, {"BETA", 32'd0}, 8'd128, 16'h00FF);
    send_task(ptp_pkg::OP_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 8'd128, 16'hAAAA);
    send_task(ptp_pkg::OP_ADD, 64'h5555_5555_5555_5555, 8'd128, 16'h5555);
    repeat (8) send_task(ptp_pkg::OP_PICK, '1, '1, '1);

    for (phase = 0; phase < 3; phase++) begin
      send_gap_pct   = (phase == 0) ? 7 : (phase == 1) ? 47 : 0;
      recv_stall_pct = (phase == 0) ? 47 : (phase == 1) ? 7 : 0;
      for (n = 0; n < 400; n++) begin
        // random filling, draining and balanced runs so the table hits full and empty
        if (run_left == 0) begin
          run_left = $urandom_range(20, 70);
          case ($urandom_range(2))
            0:       add_pct = 85;
            1:       add_pct = 20;
            default: add_pct = 50;
          endcase
        end
        run_left--;
        if ($urandom_range(99) < add_pct)
          send_task(ptp_pkg::OP_ADD, random_name(), random_prio(), random_burst());
        else
          send_task(ptp_pkg::OP_PICK, random_name(), random_prio(), random_burst());
      end
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
